// ===== rtl/mste_pkg.sv =====
`timescale 1ns / 1ps
package mste_pkg;
    localparam logic [3:0] REQ_ENQ       = 4'd0;
    localparam logic [3:0] REQ_FIND_ID   = 4'd1;
    localparam logic [3:0] REQ_FIND_ST   = 4'd2;
    localparam logic [3:0] REQ_DEL_SLOT  = 4'd3;
    localparam logic [3:0] REQ_DEL_ID    = 4'd4;
    localparam logic [3:0] REQ_SET_ST    = 4'd5;
    localparam logic [3:0] REQ_SET_TICK  = 4'd6;
    localparam logic [3:0] REQ_EXP_ONE   = 4'd7;
    localparam logic [3:0] REQ_EXP_ALL   = 4'd8;
    localparam logic [3:0] REQ_CLEAR     = 4'd9;
    localparam logic [3:0] REQ_READ      = 4'd10;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NONE     = 2'd1;
    localparam logic [1:0] ST_REJECT   = 2'd2;
    localparam logic [1:0] ST_OVERWR   = 2'd3;

    localparam logic [3:0] KIND_PUBLISH = 4'd3;
    localparam logic [31:0] TIMEOUT_RST = 32'd30000;

    // one request word, fields from the highest bit down
    typedef struct packed {
        logic [31:0] tick_value;
        logic [1:0]  wanted_state;
        logic [27:0] remaining_length;
        logic [15:0] data_length;
        logic [1:0]  service_level;
        logic [3:0]  message_kind;
        logic [15:0] message_id;
        logic [2:0]  slot_sel;
        logic [3:0]  req_type;
    } t_req;

    // match test controls from sequencer to compare unit
    typedef struct packed {
        logic [3:0]  req_type;
        logic [15:0] message_id;
        logic [1:0]  wanted_state;
    } t_cmp_ctl;
endpackage

// ===== rtl/mste_match.sv =====
`timescale 1ns / 1ps
module mste_match #(
    parameter int TICK_BITS = 32
) (
    input  mste_pkg::t_cmp_ctl   i_ctl,
    input  logic                 i_used,
    input  logic [15:0]          i_id,
    input  logic [1:0]           i_state,
    input  logic [TICK_BITS-1:0] i_tick,
    input  logic [TICK_BITS-1:0] i_now,
    input  logic [31:0]          i_timeout,
    output logic                 o_hit
);
    import mste_pkg::*;
    logic [TICK_BITS-1:0] w_diff;
    logic                 w_exp;

    assign w_diff = i_now - i_tick;
    always_comb begin
        if (TICK_BITS > 32) w_exp = w_diff > TICK_BITS'(i_timeout);
        else w_exp = 33'(w_diff) > {1'b0, i_timeout};
    end

    always_comb begin
        unique case (i_ctl.req_type) inside
            REQ_ENQ: o_hit = !i_used;
            REQ_FIND_ST: o_hit = i_used && i_state == i_ctl.wanted_state;
            REQ_FIND_ID, REQ_DEL_ID, REQ_SET_ST, REQ_SET_TICK:
                o_hit = i_used && i_id == i_ctl.message_id;
            REQ_EXP_ONE, REQ_EXP_ALL: o_hit = i_used && w_exp;
            default: o_hit = 1'b0;
        endcase
    end
endmodule

// ===== rtl/message_slot_table_with_expiry.sv =====
`timescale 1ns / 1ps
// Message slot table with expiry.
// Requests enter on the s_axis group; tdata packs req_type, slot_sel,
// message_id, message_kind, service_level, data_length, remaining_length,
// wanted_state and tick_value from the lowest bit up. One result word leaves
// on the m_axis group per request. The expiry timeout is written on the
// cfg channel; the user must write it only while the block is idle, as the
// block itself does not enforce this. Each searching request scans the
// table one slot per cycle through a single shared compare unit; table-wide
// scans run full length, hits stop early. An accepted enqueue also passes
// S_SUB for the byte total update. Direct-slot, clear and unknown requests
// do not search the table. s_axis_tready is high only in idle, so one
// request is in flight at a time; the next request can be taken the cycle
// after the result word is accepted.
// Reset empties the table, zeroes the byte total and loads a timeout of
// 30000. When the receiver stalls, the result holds in the output register
// and no new request is taken until it is accepted.
module message_slot_table_with_expiry #(
    parameter int SLOT_COUNT = 8,
    parameter int TICK_BITS  = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // req_type, slot_sel, message_id, message_kind, service_level,
    // data_length, remaining_length, wanted_state, tick_value, pad
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status, slot_out, id_out, kind_out, level_out, length_out,
    // state_out, tick_out, removed_count, byte_total, pad
    output logic [119:0] m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data
);
    import mste_pkg::*;
    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_ACT  = 3'd2;
    localparam logic [2:0] S_OUT  = 3'd3;
    localparam logic [2:0] S_SUB  = 3'd4;

    logic [2:0]           r_st;
    t_req                 r_req;
    logic [31:0]          r_timeout;
    logic [31:0]          r_total;
    logic [IW-1:0]        r_idx;
    logic                 r_found;
    logic [IW-1:0]        r_hit;
    logic [CW-1:0]        r_removed;
    logic [SLOT_COUNT-1:0] r_used;
    logic [15:0]          r_id   [SLOT_COUNT];
    logic [3:0]           r_kind [SLOT_COUNT];
    logic [1:0]           r_lvl  [SLOT_COUNT];
    logic [15:0]          r_dlen [SLOT_COUNT];
    logic [28:0]          r_size [SLOT_COUNT];
    logic [1:0]           r_sst  [SLOT_COUNT];
    logic [TICK_BITS-1:0] r_tick [SLOT_COUNT];
    logic [1:0]           r_status;
    logic [28:0]          r_sub;
    logic                 r_rem;

    t_cmp_ctl w_ctl;
    logic     w_hit;
    logic     w_last;
    logic     w_sel_ok;
    logic [IW-1:0] w_sel;
    logic [32:0] w_add;
    logic [28:0] w_newsize;
    logic        w_enq_rej;
    logic        w_slot_ok;
    logic [IW-1:0] w_enq_idx;
    logic [1:0]  w_act_status;
    logic        w_act_rem;
    logic [31:0] w_total_rem;
    logic [119:0] w_out;

    assign s_axis_tready = r_st == S_IDLE;
    assign cfg_ready     = 1'b1;
    assign w_ctl = '{req_type: r_req.req_type, message_id: r_req.message_id,
                     wanted_state: r_req.wanted_state};
    assign w_last = 32'(r_idx) == SLOT_COUNT - 1;
    assign w_sel  = IW'(r_req.slot_sel);
    assign w_sel_ok = 32'(r_req.slot_sel) < SLOT_COUNT;
    assign w_newsize = 29'(r_req.data_length) + 29'(r_req.remaining_length);
    assign w_enq_rej = r_req.service_level == 2'd1 && r_req.message_kind == KIND_PUBLISH;
    assign w_slot_ok = w_sel_ok && r_used[w_sel];
    assign w_enq_idx = r_found ? r_hit : '0;

    mste_match #(.TICK_BITS(TICK_BITS)) u_match (
        .i_ctl(w_ctl), .i_used(r_used[r_idx]), .i_id(r_id[r_idx]),
        .i_state(r_sst[r_idx]), .i_tick(r_tick[r_idx]),
        .i_now(TICK_BITS'(r_req.tick_value)), .i_timeout(r_timeout), .o_hit(w_hit)
    );

    function automatic logic [31:0] sat_sub(logic [31:0] a, logic [28:0] b);
        return (33'(b) > 33'(a)) ? 32'd0 : a - 32'(b);
    endfunction

    assign w_add = 33'(r_total) + 33'(r_sub);
    assign w_total_rem = sat_sub(r_total, r_size[r_hit]);

    always_comb begin
        w_act_status = r_found ? ST_OK : ST_NONE;
        w_act_rem = 1'b0;
        case (r_req.req_type) inside
            REQ_ENQ: begin
                if (w_enq_rej) w_act_status = ST_REJECT;
                else w_act_status = r_found ? ST_OK : ST_OVERWR;
            end
            REQ_DEL_SLOT, REQ_READ: begin
                w_act_status = w_slot_ok ? ST_OK : ST_NONE;
                w_act_rem = w_slot_ok && r_req.req_type == REQ_DEL_SLOT;
            end
            REQ_DEL_ID, REQ_EXP_ONE: w_act_rem = r_found;
            REQ_EXP_ALL, REQ_CLEAR: w_act_status = ST_OK;
            default: w_act_rem = 1'b0;
        endcase
    end

    always_comb begin
        w_out = '0;
        w_out[1:0] = r_status;
        if (r_found) begin
            w_out[4:2]   = 3'(r_hit);
            w_out[20:5]  = r_id[r_hit];
            w_out[24:21] = r_kind[r_hit];
            w_out[26:25] = r_lvl[r_hit];
            w_out[42:27] = r_dlen[r_hit];
            w_out[44:43] = r_sst[r_hit];
            w_out[76:45] = 32'(r_tick[r_hit]);
        end
        w_out[80:77] = 4'(r_removed);
        w_out[112:81] = r_rem ? w_total_rem : r_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_timeout <= TIMEOUT_RST;
            r_total <= '0;
            r_used <= '0;
            m_axis_tvalid <= 1'b0;
        end else begin
            if (cfg_valid) r_timeout <= cfg_data;
            unique case (r_st)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_req <= t_req'(s_axis_tdata[106:0]);
                        r_idx <= '0;
                        r_found <= 1'b0;
                        r_hit <= '0;
                        r_removed <= '0;
                        r_st <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    case (r_req.req_type) inside
                        REQ_DEL_SLOT, REQ_READ, REQ_CLEAR: r_st <= S_ACT;
                        REQ_EXP_ALL: begin
                            if (w_hit) begin
                                r_used[r_idx] <= 1'b0;
                                r_total <= sat_sub(r_total, r_size[r_idx]);
                                r_removed <= r_removed + 1'b1;
                            end
                            if (w_last) r_st <= S_ACT;
                            r_idx <= r_idx + 1'b1;
                        end
                        default: begin
                            if (w_hit || w_last || r_req.req_type > REQ_READ) begin
                                r_found <= w_hit;
                                r_hit <= r_idx;
                                r_st <= S_ACT;
                            end else r_idx <= r_idx + 1'b1;
                        end
                    endcase
                end
                S_ACT: begin
                    r_rem <= w_act_rem;
                    r_status <= w_act_status;
                    r_st <= (r_req.req_type == REQ_ENQ && !w_enq_rej) ? S_SUB : S_OUT;
                    case (r_req.req_type) inside
                        REQ_ENQ: begin
                            if (w_enq_rej) begin
                                r_found <= 1'b0;
                            end else begin
                                r_found <= 1'b1;
                                if (!r_found) begin
                                    r_hit <= '0;
                                    r_total <= sat_sub(r_total, r_size[0]);
                                end
                                r_used[w_enq_idx] <= 1'b1;
                                r_id[w_enq_idx]   <= r_req.message_id;
                                r_kind[w_enq_idx] <= r_req.message_kind;
                                r_lvl[w_enq_idx]  <= r_req.service_level;
                                r_dlen[w_enq_idx] <= r_req.data_length;
                                r_size[w_enq_idx] <= w_newsize;
                                r_sst[w_enq_idx]  <= 2'd0;
                                r_tick[w_enq_idx] <= TICK_BITS'(r_req.tick_value);
                                r_sub <= w_newsize;
                            end
                        end
                        REQ_DEL_SLOT, REQ_READ: begin
                            if (w_slot_ok) begin
                                r_found <= 1'b1;
                                r_hit <= w_sel;
                            end
                        end
                        REQ_SET_ST: if (r_found) r_sst[r_hit] <= r_req.wanted_state;
                        REQ_SET_TICK:
                            if (r_found) r_tick[r_hit] <= TICK_BITS'(r_req.tick_value);
                        REQ_EXP_ALL: r_found <= 1'b0;
                        REQ_CLEAR: begin
                            r_used <= '0;
                            r_total <= '0;
                        end
                        default: ;
                    endcase
                end
                S_SUB: begin
                    // add the new entry size, saturating
                    r_total <= w_add[32] ? 32'hFFFF_FFFF : w_add[31:0];
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    if (!m_axis_tvalid) begin
                        m_axis_tdata <= w_out;
                        if (r_rem) begin
                            r_used[r_hit] <= 1'b0;
                            r_total <= w_total_rem;
                        end
                        m_axis_tvalid <= 1'b1;
                    end else if (m_axis_tready) begin
                        m_axis_tvalid <= 1'b0;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");
    a_removed_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_removed) <= SLOT_COUNT) else $error("removed count overflow");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_ACT && r_req.req_type == REQ_CLEAR) |=> r_used == '0)
        else $error("clear left slots");
endmodule
